// File: sv/rcri_pkg.sv
// Shared types and codes for the reference-counted resource table.
`timescale 1ns / 1ps
package rcri_pkg;
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W = 3;
    localparam int CNT_W = 4;

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_ADD      = 3'd1;
    localparam logic [2:0] CMD_RELEASE  = 3'd2;
    localparam logic [2:0] CMD_REFRESH  = 3'd3;
    localparam logic [2:0] CMD_CHECK    = 3'd4;

    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_IDLE    = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_CREATE  = 2'd1;
    localparam logic [1:0] EV_DESTROY = 2'd2;

    localparam logic [2:0] S_OK         = 3'd0;
    localparam logic [2:0] S_FULL       = 3'd1;
    localparam logic [2:0] S_UNREG      = 3'd2;
    localparam logic [2:0] S_NOREF      = 3'd3;
    localparam logic [2:0] S_BAD        = 3'd4;
    localparam logic [2:0] S_BADREFRESH = 3'd5;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       timeout_ms;
        logic [31:0]       now_ms;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] res_slot;
        logic [1:0]        event_res;
        logic [2:0]        status;
        logic              slot_free;
        logic              last;
    } res_t;
endpackage

// File: sv/refcount_resource_idle_release_core.sv
// Top level of the reference-counted resource table with idle release.
`timescale 1ns / 1ps
// Usage: commands enter through a queue-style port. A beat is taken at a
// rising edge with push high and full low; it carries cmd, slot, timeout_ms
// and now_ms. Results leave through a second queue-style port: while empty
// is low the oldest result is on res_slot, event_res, status, slot_free and
// last, and it is taken at an edge with pop high.
// Every command but check gives one result beat. Check walks all slots, one
// per cycle, and gives one destroy beat per expired slot in ascending order,
// or one beat with no event; last marks the final beat of a command.
// A simple command's result passes through the command queue, the engine's
// result register and the result queue before it reaches the ports; a check
// first walks every slot and then sends its beats one after another. The
// single engine that owns the slot table takes no new command until the last
// beat of the current one has been handed to the result queue.
// A two-entry command queue lets the front keep accepting while the engine
// works, and a two-entry result queue decouples the consumer. When the
// consumer stalls the engine holds its beat and the command queue fills,
// then full rises. Reset clears all slots to free and the table to empty.
module refcount_resource_idle_release_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  cmd,
    input  logic [2:0]  slot,
    input  logic [31:0] timeout_ms,
    input  logic [31:0] now_ms,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  res_slot,
    output logic [1:0]  event_res,
    output logic [2:0]  status,
    output logic        slot_free,
    output logic        last
);
    rcri_pkg::cmd_t in_beat, q_beat;
    rcri_pkg::res_t eng_res, out_res;
    logic q_empty, q_take, eng_valid, eng_take;

    assign in_beat = '{cmd: cmd, slot: slot, timeout_ms: timeout_ms, now_ms: now_ms};

    rcri_cmd_fifo u_cmdq (
        .clk(clk), .rst_n(rst_n), .wr_en(push), .wr_data(in_beat), .full(full),
        .rd_en(q_take), .rd_data(q_beat), .empty(q_empty)
    );

    rcri_engine u_eng (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_beat),
        .cmd_take(q_take), .res_valid(eng_valid), .res(eng_res), .res_take(eng_take)
    );

    rcri_out_fifo u_outq (
        .clk(clk), .rst_n(rst_n), .in_valid(eng_valid), .in_data(eng_res),
        .in_take(eng_take), .pop(pop), .rd_data(out_res), .empty(empty)
    );

    assign res_slot  = out_res.res_slot;
    assign event_res = out_res.event_res;
    assign status    = out_res.status;
    assign slot_free = out_res.slot_free;
    assign last      = out_res.last;

    // A destroy event always reports the slot as free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res == rcri_pkg::EV_DESTROY) |-> slot_free)
        else $error("destroy beat without free slot");

    // A create event comes only with ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res == rcri_pkg::EV_CREATE) |-> (status == rcri_pkg::S_OK && !slot_free))
        else $error("create beat with bad status");

    // The engine takes no command while a result beat is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        eng_valid |-> !q_take)
        else $error("command taken during output");
endmodule

// File: sv/rcri_cmd_fifo.sv
// Two-entry command queue between the front end and the execution engine.
`timescale 1ns / 1ps
module rcri_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  rcri_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output rcri_pkg::cmd_t rd_data,
    output logic           empty
);
    rcri_pkg::cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
        end
    end
endmodule

// File: sv/rcri_engine.sv
// Execution engine: holds the slot table and runs one command at a time.
`timescale 1ns / 1ps
module rcri_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  rcri_pkg::cmd_t cmd,
    output logic           cmd_take,
    output logic           res_valid,
    output rcri_pkg::res_t res,
    input  logic           res_take
);
    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_SCAN = 2'd1;
    localparam logic [1:0] E_OUT  = 2'd2;
    localparam logic [1:0] E_PICK = 2'd3;

    logic [31:0] tmo_reg   [rcri_pkg::NUM_SLOTS];
    logic [31:0] stamp_reg [rcri_pkg::NUM_SLOTS];
    logic [15:0] ref_reg   [rcri_pkg::NUM_SLOTS];
    logic [1:0]  st_reg    [rcri_pkg::NUM_SLOTS];
    logic [rcri_pkg::CNT_W-1:0]     nreg_reg;
    logic [1:0]                     fsm_reg;
    logic [rcri_pkg::SLOT_W-1:0]    idx_reg;
    logic [31:0]                    now_reg;
    rcri_pkg::res_t                 res_reg;
    logic [rcri_pkg::NUM_SLOTS-1:0] mask_reg;

    logic [rcri_pkg::SLOT_W-1:0]    s;
    logic                           reg_ok;
    logic [31:0]                    elapsed;
    logic                           expire;
    logic                           scan_end;
    logic [15:0]                    rc;
    logic [1:0]                     sst;
    logic [rcri_pkg::SLOT_W-1:0]    pick_idx;
    logic [rcri_pkg::NUM_SLOTS-1:0] mask_rest;

    assign s        = cmd.slot;
    assign rc       = ref_reg[s];
    assign sst      = st_reg[s];
    assign reg_ok   = {1'b0, s} < nreg_reg;
    assign elapsed  = now_reg - stamp_reg[idx_reg];
    assign expire   = ({1'b0, idx_reg} < nreg_reg) && (st_reg[idx_reg] == rcri_pkg::ST_IDLE)
                      && (elapsed >= tmo_reg[idx_reg]);
    assign scan_end = ({1'b0, idx_reg} == rcri_pkg::CNT_W'(rcri_pkg::NUM_SLOTS - 1));
    assign cmd_take  = (fsm_reg == E_IDLE) && cmd_valid;
    assign res_valid = (fsm_reg == E_OUT);
    assign res       = res_reg;

    // Lowest expired slot still waiting to be reported, and the set left after it.
    always_comb
    begin
        pick_idx = '0;
        for (int i = rcri_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_idx = rcri_pkg::SLOT_W'(i);
            end
        end
        mask_rest = mask_reg;
        mask_rest[pick_idx] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.cmd == rcri_pkg::CMD_REGISTER
            && nreg_reg < rcri_pkg::CNT_W'(rcri_pkg::NUM_SLOTS))
        begin
            tmo_reg[nreg_reg[rcri_pkg::SLOT_W-1:0]] <= cmd.timeout_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        rcri_pkg::res_t beat;
        if (!rst_n)
        begin
            for (int i = 0; i < rcri_pkg::NUM_SLOTS; i++)
            begin
                stamp_reg[i] <= 32'd0;
                ref_reg[i]   <= 16'd0;
                st_reg[i]    <= rcri_pkg::ST_FREE;
            end
            nreg_reg <= '0;
            fsm_reg  <= E_IDLE;
            idx_reg  <= '0;
            now_reg  <= 32'd0;
            res_reg  <= '0;
            mask_reg <= '0;
        end
        else
        begin
            beat = res_reg;
            case (fsm_reg)
                E_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        fsm_reg <= E_OUT;
                        beat = '{res_slot: s, event_res: rcri_pkg::EV_NONE,
                                 status: rcri_pkg::S_OK, slot_free: 1'b0, last: 1'b1};
                        case (cmd.cmd)
                            rcri_pkg::CMD_REGISTER:
                            begin
                                if (nreg_reg >= rcri_pkg::CNT_W'(rcri_pkg::NUM_SLOTS))
                                begin
                                    beat.res_slot = '0;
                                    beat.status   = rcri_pkg::S_FULL;
                                end
                                else
                                begin
                                    stamp_reg[nreg_reg[rcri_pkg::SLOT_W-1:0]] <= 32'd0;
                                    ref_reg[nreg_reg[rcri_pkg::SLOT_W-1:0]]   <= 16'd0;
                                    st_reg[nreg_reg[rcri_pkg::SLOT_W-1:0]]    <= rcri_pkg::ST_FREE;
                                    nreg_reg <= nreg_reg + 1'b1;
                                    beat.res_slot  = nreg_reg[rcri_pkg::SLOT_W-1:0];
                                    beat.slot_free = 1'b1;
                                end
                            end
                            rcri_pkg::CMD_ADD, rcri_pkg::CMD_RELEASE, rcri_pkg::CMD_REFRESH:
                            begin
                                if (!reg_ok)
                                begin
                                    beat.status    = rcri_pkg::S_UNREG;
                                    beat.slot_free = 1'b1;
                                end
                                else if (cmd.cmd == rcri_pkg::CMD_ADD)
                                begin
                                    beat.slot_free = (sst == rcri_pkg::ST_FREE);
                                    if (rc == 16'hFFFF)
                                    begin
                                        beat.status = rcri_pkg::S_BAD;
                                    end
                                    else if (rc != 16'd0)
                                    begin
                                        ref_reg[s] <= rc + 16'd1;
                                    end
                                    else if (sst == rcri_pkg::ST_FREE || sst == rcri_pkg::ST_IDLE)
                                    begin
                                        st_reg[s]  <= rcri_pkg::ST_CREATED;
                                        ref_reg[s] <= 16'd1;
                                        beat.slot_free = 1'b0;
                                        if (sst == rcri_pkg::ST_FREE)
                                        begin
                                            beat.event_res = rcri_pkg::EV_CREATE;
                                        end
                                    end
                                    else
                                    begin
                                        beat.status = rcri_pkg::S_BAD;
                                    end
                                end
                                else if (cmd.cmd == rcri_pkg::CMD_RELEASE)
                                begin
                                    beat.slot_free = (sst == rcri_pkg::ST_FREE);
                                    if (rc == 16'd0)
                                    begin
                                        beat.status = rcri_pkg::S_NOREF;
                                    end
                                    else
                                    begin
                                        ref_reg[s] <= rc - 16'd1;
                                        if (rc == 16'd1)
                                        begin
                                            if (tmo_reg[s] == 32'd0)
                                            begin
                                                st_reg[s] <= rcri_pkg::ST_FREE;
                                                beat.event_res = rcri_pkg::EV_DESTROY;
                                                beat.slot_free = 1'b1;
                                            end
                                            else
                                            begin
                                                stamp_reg[s] <= cmd.now_ms;
                                                st_reg[s]    <= rcri_pkg::ST_IDLE;
                                                beat.slot_free = 1'b0;
                                            end
                                        end
                                    end
                                end
                                else
                                begin
                                    beat.slot_free = (sst == rcri_pkg::ST_FREE);
                                    if (tmo_reg[s] == 32'd0 && sst == rcri_pkg::ST_IDLE)
                                    begin
                                        beat.status = rcri_pkg::S_BADREFRESH;
                                    end
                                    else
                                    begin
                                        stamp_reg[s] <= cmd.now_ms;
                                    end
                                end
                            end
                            rcri_pkg::CMD_CHECK:
                            begin
                                fsm_reg  <= E_SCAN;
                                idx_reg  <= '0;
                                mask_reg <= '0;
                                now_reg  <= cmd.now_ms;
                            end
                            default:
                            begin
                                beat.res_slot = '0;
                                beat.status   = rcri_pkg::S_BAD;
                            end
                        endcase
                    end
                end
                E_SCAN:
                begin
                    // One slot per cycle; expired slots are freed and marked, and
                    // their beats go out once the walk is over so that the final
                    // destroy beat can carry last.
                    if (expire)
                    begin
                        st_reg[idx_reg]   <= rcri_pkg::ST_FREE;
                        mask_reg[idx_reg] <= 1'b1;
                    end
                    if (scan_end)
                    begin
                        fsm_reg <= E_PICK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                E_PICK:
                begin
                    fsm_reg <= E_OUT;
                    if (mask_reg == '0)
                    begin
                        beat = '{res_slot: '0, event_res: rcri_pkg::EV_NONE,
                                 status: rcri_pkg::S_OK, slot_free: 1'b0, last: 1'b1};
                    end
                    else
                    begin
                        beat = '{res_slot: pick_idx, event_res: rcri_pkg::EV_DESTROY,
                                 status: rcri_pkg::S_OK, slot_free: 1'b1,
                                 last: (mask_rest == '0)};
                        mask_reg <= mask_rest;
                    end
                end
                E_OUT:
                begin
                    if (res_take)
                    begin
                        if (res_reg.last)
                        begin
                            fsm_reg <= E_IDLE;
                        end
                        else
                        begin
                            fsm_reg <= E_PICK;
                        end
                    end
                end
                default:
                begin
                    fsm_reg <= E_IDLE;
                end
            endcase
            res_reg <= beat;
        end
    end
endmodule

// File: sv/rcri_out_fifo.sv
// Two-entry result queue that presents beats to the consumer.
`timescale 1ns / 1ps
module rcri_out_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rcri_pkg::res_t in_data,
    output logic           in_take,
    input  logic           pop,
    output rcri_pkg::res_t rd_data,
    output logic           empty
);
    rcri_pkg::res_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr;

    assign in_take = in_valid && (cnt_reg != 2'd2);
    assign wr      = in_take;
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, pop && !empty};
        end
    end
endmodule
